// ===== hw/rtl/gspr_pkg.sv =====
// gspr_pkg: shared constants, direction and command codes, and the
// controller/datapath command and status structs of the grid path router.
// No dependencies; used by gspr_ctrl, gspr_dpath and the top level.
package gspr_pkg;

    // distance word and the "not reached" level
    localparam int DIST_BITS = 12;
    localparam logic [DIST_BITS-1:0] DIST_INF = 12'hFFF;

    // a reported path holds at most this many nodes
    localparam int PATH_MAX  = 16;
    localparam int PATH_BITS = 4;

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // grid move codes
    localparam logic [2:0] DIR_NORTH = 3'd0;
    localparam logic [2:0] DIR_EAST  = 3'd1;
    localparam logic [2:0] DIR_SOUTH = 3'd2;
    localparam logic [2:0] DIR_WEST  = 3'd3;
    localparam logic [2:0] DIR_NONE  = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;    // write one zero weight of the clearing pass
        logic edge_wr;     // store the weight of the accepted write beat
        logic q_load;      // latch start and goal of the accepted query beat
        logic q_init;      // clear search flags, distance of start to zero
        logic scan_init;   // restart the minimum scan
        logic scan_step;   // one node of the minimum scan
        logic settle;      // settle the scan winner, restart the counter
        logic relax_step;  // one node of the relaxation
        logic walk_init;   // start the predecessor walk at the goal
        logic walk_step;   // buffer the current node, fetch its predecessor
        logic walk_load;   // take the fetched predecessor
        logic out_prime;   // fetch the start node from the path buffer
        logic out_load;    // take the start node, fetch the next one
        logic out_step;    // send one path result
        logic emit_fail;   // send the unreachable result
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;     // clearing pass is at its final entry
        logic q_ok;         // start and goal are valid node numbers
        logic seq_done;     // scan or relaxation counter has run through
        logic found;        // the scan found an unsettled reached node
        logic best_is_goal; // the scan winner is the goal
        logic walk_end;     // walk is at the start or at the node limit
        logic walk_ok;      // walk ended at the start within the path limit
        logic out_more;     // a further path node follows the current one
    } t_dp_stat;

endpackage

// ===== hw/rtl/grid_shortest_path_router_top.sv =====
// grid_shortest_path_router_top: shortest-path router over a grid of cells,
// edge weights in a RAM, Dijkstra search with a one-node-a-cycle datapath.
// Depends on gspr_pkg, gspr_ctrl, gspr_dpath and gspr_ram.
//
//   channel  | handshake             | fields
//   ---------+-----------------------+---------------------------------------
//   command  | start in, busy out    | cmd, from/to node, weight, start/goal
//   result   | o_valid strobe out    | path index/node, direction, unreach, last
//
// A write beat is taken while idle and busy stays low. A query beat keeps busy high
// through the search, the predecessor walk and the result readout: minimum scan and
// relaxation each run over all nodes through the registered RAM reads, one node a
// cycle. Each result beat is registered from its readout step.
// After reset a clearing pass writes NODES * NODES zero weights, one a cycle,
// with busy high. Each result beat is on the ports for one cycle; the receiver
// takes every beat and cannot stall.
module grid_shortest_path_router_top #(
    parameter int NODES       = 16,
    parameter int GRID_WIDTH  = 4,
    parameter int WEIGHT_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cmd,
    input  logic [3:0] i_from_node,
    input  logic [3:0] i_to_node,
    input  logic [7:0] i_weight,
    input  logic [3:0] i_start_node,
    input  logic [3:0] i_goal_node,
    output logic       o_valid,
    output logic [3:0] o_path_index,
    output logic [3:0] o_path_node,
    output logic [2:0] o_step_direction,
    output logic       o_unreachable,
    output logic       o_last
);

    import gspr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    gspr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // memories, search and result datapath
    gspr_dpath #(
        .NODES       (NODES),
        .GRID_WIDTH  (GRID_WIDTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_from_node      (i_from_node),
        .i_to_node        (i_to_node),
        .i_weight         (i_weight),
        .i_start_node     (i_start_node),
        .i_goal_node      (i_goal_node),
        .o_valid          (o_valid),
        .o_path_index     (o_path_index),
        .o_path_node      (o_path_node),
        .o_step_direction (o_step_direction),
        .o_unreachable    (o_unreachable),
        .o_last           (o_last)
    );

endmodule

// ===== hw/rtl/gspr_ram.sv =====
// gspr_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
module gspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gspr_ctrl.sv =====
// gspr_ctrl: sequencing state machine of the grid path router.
// Depends on gspr_pkg (command and status structs, command codes).
module gspr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_cmd,
    input  gspr_pkg::t_dp_stat i_stat,
    output gspr_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    import gspr_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_QCHK   = 12'b0000_0000_0100,
        S_SCAN   = 12'b0000_0000_1000,
        S_DECIDE = 12'b0000_0001_0000,
        S_RELAX  = 12'b0000_0010_0000,
        S_WALK   = 12'b0000_0100_0000,
        S_WAIT   = 12'b0000_1000_0000,
        S_OPRIME = 12'b0001_0000_0000,
        S_OLOAD  = 12'b0010_0000_0000,
        S_OSTEP  = 12'b0100_0000_0000,
        S_FAIL   = 12'b1000_0000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    // state register, clearing pass runs first after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_QUERY) begin
                        w_cmd.q_load = 1'b1;
                        n_state      = S_QCHK;
                    end else begin
                        w_cmd.edge_wr = 1'b1;
                    end
                end
            end
            S_QCHK: begin
                if (i_stat.q_ok) begin
                    w_cmd.q_init    = 1'b1;
                    w_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_SCAN: begin
                w_cmd.scan_step = 1'b1;
                if (i_stat.seq_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.found) begin
                    n_state = S_FAIL;
                end else if (i_stat.best_is_goal) begin
                    w_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end else begin
                    w_cmd.settle = 1'b1;
                    n_state      = S_RELAX;
                end
            end
            S_RELAX: begin
                w_cmd.relax_step = 1'b1;
                if (i_stat.seq_done) begin
                    n_state = S_RELAX;
                    w_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_WALK: begin
                w_cmd.walk_step = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = i_stat.walk_ok ? S_OPRIME : S_FAIL;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                w_cmd.walk_load = 1'b1;
                n_state         = S_WALK;
            end
            S_OPRIME: begin
                w_cmd.out_prime = 1'b1;
                n_state         = S_OLOAD;
            end
            S_OLOAD: begin
                w_cmd.out_load = 1'b1;
                n_state        = S_OSTEP;
            end
            S_OSTEP: begin
                w_cmd.out_step = 1'b1;
                if (!i_stat.out_more) begin
                    n_state = S_IDLE;
                end
            end
            S_FAIL: begin
                w_cmd.emit_fail = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/gspr_dpath.sv =====
// gspr_dpath: weight, distance, predecessor and path memories, the scan and
// relaxation counter, search flags, path walk and the result registers.
// Depends on gspr_pkg and gspr_ram.
module gspr_dpath #(
    parameter int NODES       = 16,
    parameter int GRID_WIDTH  = 4,
    parameter int WEIGHT_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gspr_pkg::t_dp_cmd  i_cmd,
    output gspr_pkg::t_dp_stat o_stat,
    input  logic [3:0]         i_from_node,
    input  logic [3:0]         i_to_node,
    input  logic [7:0]         i_weight,
    input  logic [3:0]         i_start_node,
    input  logic [3:0]         i_goal_node,
    output logic               o_valid,
    output logic [3:0]         o_path_index,
    output logic [3:0]         o_path_node,
    output logic [2:0]         o_step_direction,
    output logic               o_unreachable,
    output logic               o_last
);

    import gspr_pkg::*;

    localparam int NB = $clog2(NODES);           // node number
    localparam int CB = $clog2(NODES + 1);       // node count
    localparam int AB = $clog2(NODES * NODES);   // weight memory address
    localparam int SB = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
    localparam int DB = NB + 5;                  // room for node plus grid width

    // control registers
    logic [AB-1:0]        r_clr;
    logic [NODES-1:0]     r_reached;
    logic [NODES-1:0]     r_settled;
    logic [CB-1:0]        r_cnt;
    logic                 r_pv;
    logic                 r_found;
    logic                 r_valid;

    // payload registers
    logic [3:0]           r_start_raw;
    logic [3:0]           r_goal_raw;
    logic [NB-1:0]        r_pi;
    logic [DIST_BITS-1:0] r_best;
    logic [NB-1:0]        r_m;
    logic [NB-1:0]        r_j;
    logic [CB-1:0]        r_count;
    logic [PATH_BITS-1:0] r_k;
    logic [PATH_BITS-1:0] r_a;
    logic [NB-1:0]        r_cur;
    logic [3:0]           r_o_index;
    logic [3:0]           r_o_node;
    logic [2:0]           r_o_dir;
    logic                 r_o_unr;
    logic                 r_o_last;

    // memory ports
    logic                   w_e_we;
    logic [AB-1:0]          w_e_waddr;
    logic [WEIGHT_BITS-1:0] w_e_wdata;
    logic [AB-1:0]          w_e_raddr;
    logic [WEIGHT_BITS-1:0] w_e_rdata;
    logic                   w_d_we;
    logic [NB-1:0]          w_d_waddr;
    logic [DIST_BITS-1:0]   w_d_wdata;
    logic [DIST_BITS-1:0]   w_d_rdata;
    logic                   w_p_we;
    logic [NB-1:0]          w_p_rdata;
    logic                   w_b_we;
    logic [PATH_BITS-1:0]   w_b_waddr;
    logic [PATH_BITS-1:0]   w_b_raddr;
    logic [NB-1:0]          w_b_rdata;

    // derived values
    logic [NB-1:0]    w_start_idx;
    logic [NB-1:0]    w_goal_idx;
    logic             w_edge_ok;
    logic             w_scan_hit;
    logic [SB-1:0]    w_sum;
    logic             w_upd;
    logic             w_more;
    logic [NODES-1:0] w_first_col;
    logic [NODES-1:0] w_last_col;
    logic [DB-1:0]    w_a;
    logic [DB-1:0]    w_b;
    logic [2:0]       w_dir;
    logic [NODES-1:0] w_start_hot;

    assign w_start_idx = NB'(r_start_raw);
    assign w_goal_idx  = NB'(r_goal_raw);
    assign w_edge_ok   = (int'(i_from_node) < NODES) && (int'(i_to_node) < NODES);

    // column table of the grid
    for (genvar g = 0; g < NODES; g++) begin : g_col
        localparam int COL = g % GRID_WIDTH;
        assign w_first_col[g] = (COL == 0);
        assign w_last_col[g]  = (COL == GRID_WIDTH - 1);
    end

    // edge weight memory: clearing pass or a write beat
    assign w_e_we    = i_cmd.clr_step || (i_cmd.edge_wr && w_edge_ok);
    assign w_e_waddr = i_cmd.clr_step ? r_clr
                     : AB'(i_from_node) * AB'(NODES) + AB'(i_to_node);
    assign w_e_wdata = i_cmd.clr_step ? '0 : WEIGHT_BITS'(i_weight);
    assign w_e_raddr = AB'(r_m) * AB'(NODES) + AB'(r_cnt[NB-1:0]);

    gspr_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(NODES * NODES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_e_we),
        .i_waddr (w_e_waddr),
        .i_wdata (w_e_wdata),
        .i_raddr (w_e_raddr),
        .o_rdata (w_e_rdata)
    );

    // distance memory: start seeded at query init, improved by relaxation
    assign w_d_we    = i_cmd.q_init || (i_cmd.relax_step && w_upd);
    assign w_d_waddr = i_cmd.q_init ? w_start_idx : r_pi;
    assign w_d_wdata = i_cmd.q_init ? '0 : w_sum[DIST_BITS-1:0];

    gspr_ram #(.WIDTH(DIST_BITS), .DEPTH(NODES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (r_cnt[NB-1:0]),
        .o_rdata (w_d_rdata)
    );

    // predecessor memory
    assign w_p_we = i_cmd.relax_step && w_upd;

    gspr_ram #(.WIDTH(NB), .DEPTH(NODES)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (r_pi),
        .i_wdata (r_m),
        .i_raddr (r_j),
        .o_rdata (w_p_rdata)
    );

    // path buffer, goal at entry zero, start at the highest entry
    assign w_b_we    = i_cmd.walk_step && (int'(r_count) <= PATH_MAX);
    assign w_b_waddr = PATH_BITS'(r_count - CB'(1));
    assign w_b_raddr = i_cmd.out_prime ? PATH_BITS'(r_count - CB'(1)) : r_a;

    gspr_ram #(.WIDTH(NB), .DEPTH(PATH_MAX)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (r_j),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // minimum scan compare, strict less keeps the lowest index on ties
    assign w_scan_hit = r_pv && !r_settled[r_pi] && r_reached[r_pi] &&
                        (w_d_rdata < r_best);

    // relaxation with the forward weight
    assign w_sum = SB'(r_best) + SB'(w_e_rdata);
    assign w_upd = r_pv && !r_settled[r_pi] && (w_e_rdata != '0) &&
                   (w_sum < SB'(DIST_INF)) &&
                   (!r_reached[r_pi] || (w_sum < SB'(w_d_rdata)));

    assign w_more = (int'(r_k) + 1) < int'(r_count);

    // grid move from the current node to the next one
    assign w_a = DB'(r_cur);
    assign w_b = DB'(w_b_rdata);
    always_comb begin
        w_dir = DIR_NONE;
        if (!w_first_col[r_cur] && (w_b + DB'(1) == w_a)) begin
            w_dir = DIR_WEST;
        end else if (!w_last_col[r_cur] && (w_a + DB'(1) < DB'(NODES)) &&
                     (w_b == w_a + DB'(1))) begin
            w_dir = DIR_EAST;
        end else if ((w_a + DB'(GRID_WIDTH) < DB'(NODES)) &&
                     (w_b == w_a + DB'(GRID_WIDTH))) begin
            w_dir = DIR_NORTH;
        end else if ((w_a >= DB'(GRID_WIDTH)) && (w_b + DB'(GRID_WIDTH) == w_a)) begin
            w_dir = DIR_SOUTH;
        end
    end

    // one-hot of the start node for query init
    always_comb begin
        w_start_hot = '0;
        w_start_hot[w_start_idx] = 1'b1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_reached <= '0;
            r_settled <= '0;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AB'(1);
            end
            // search flags
            if (i_cmd.q_init) begin
                r_reached <= w_start_hot;
                r_settled <= '0;
            end else begin
                if (i_cmd.settle) begin
                    r_settled[r_m] <= 1'b1;
                end
                if (i_cmd.relax_step && w_upd) begin
                    r_reached[r_pi] <= 1'b1;
                end
            end
            // node counter shared by scan and relaxation
            if (i_cmd.scan_init || i_cmd.settle) begin
                r_cnt <= '0;
                r_pv  <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.relax_step) begin
                r_pv <= (r_cnt < CB'(NODES));
                if (r_cnt < CB'(NODES)) begin
                    r_cnt <= r_cnt + CB'(1);
                end
            end
            if (i_cmd.scan_init) begin
                r_found <= 1'b0;
            end else if (i_cmd.scan_step && w_scan_hit) begin
                r_found <= 1'b1;
            end
            r_valid <= i_cmd.out_step || i_cmd.emit_fail;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_start_raw <= i_start_node;
            r_goal_raw  <= i_goal_node;
        end
        if (i_cmd.scan_step || i_cmd.relax_step) begin
            r_pi <= r_cnt[NB-1:0];
        end
        if (i_cmd.scan_init) begin
            r_best <= DIST_INF;
        end else if (i_cmd.scan_step && w_scan_hit) begin
            r_best <= w_d_rdata;
            r_m    <= r_pi;
        end
        // predecessor walk
        if (i_cmd.walk_init) begin
            r_j     <= w_goal_idx;
            r_count <= CB'(1);
        end else if (i_cmd.walk_load) begin
            r_j     <= w_p_rdata;
            r_count <= r_count + CB'(1);
        end
        // path readout, start first
        if (i_cmd.out_prime) begin
            r_a <= PATH_BITS'(r_count - CB'(2));
            r_k <= '0;
        end else if (i_cmd.out_load) begin
            r_cur <= w_b_rdata;
            r_a   <= r_a - PATH_BITS'(1);
        end else if (i_cmd.out_step && w_more) begin
            r_cur <= w_b_rdata;
            r_a   <= r_a - PATH_BITS'(1);
            r_k   <= r_k + PATH_BITS'(1);
        end
        // result beat
        if (i_cmd.emit_fail) begin
            r_o_index <= '0;
            r_o_node  <= r_goal_raw;
            r_o_dir   <= DIR_NONE;
            r_o_unr   <= 1'b1;
            r_o_last  <= 1'b1;
        end else if (i_cmd.out_step) begin
            r_o_index <= r_k;
            r_o_node  <= 4'(r_cur);
            r_o_dir   <= w_more ? w_dir : DIR_NONE;
            r_o_unr   <= 1'b0;
            r_o_last  <= !w_more;
        end
    end

    // status to the controller
    assign o_stat.clr_last     = (r_clr == AB'(NODES * NODES - 1));
    assign o_stat.q_ok         = (int'(r_start_raw) < NODES) && (int'(r_goal_raw) < NODES);
    assign o_stat.seq_done     = (r_cnt == CB'(NODES));
    assign o_stat.found        = r_found;
    assign o_stat.best_is_goal = (r_m == w_goal_idx);
    assign o_stat.walk_end     = (r_j == w_start_idx) || (r_count == CB'(NODES));
    assign o_stat.walk_ok      = (r_j == w_start_idx) && (int'(r_count) <= PATH_MAX);
    assign o_stat.out_more     = w_more;

    assign o_valid          = r_valid;
    assign o_path_index     = r_o_index;
    assign o_path_node      = r_o_node;
    assign o_step_direction = r_o_dir;
    assign o_unreachable    = r_o_unr;
    assign o_last           = r_o_last;

endmodule

// ===== sim/tb_grid_shortest_path_router_top.sv =====
// tb_grid_shortest_path_router_top: self-checking bench for the grid path router.
// Drives write and query beats, predicts every path beat in-bench and checks them.
// Depends on gspr_pkg and grid_shortest_path_router_top.
`timescale 1ns / 100ps

module tb_grid_shortest_path_router_top;
    import gspr_pkg::*;

    localparam int NODE_COUNT  = 16;
    localparam int GRID_W      = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_BEATS = 130;
    localparam int PRINT_CAP   = 40;

    // serpentine tour of the grid, every step between neighbors
    localparam logic [3:0] SNAKE [NODE_COUNT] =
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd6, 4'd5, 4'd4,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd15, 4'd14, 4'd13, 4'd12};

    typedef struct packed {
        logic [3:0] idx;
        logic [3:0] node;
        logic [2:0] dir;
        logic       unr;
        logic       last;
    } t_path_beat;

    typedef struct {
        logic       cmd;
        logic [3:0] from_n;
        logic [3:0] to_n;
        logic [7:0] weight;
        logic [3:0] src;
        logic [3:0] dst;
        bit         typed;
        t_path_beat want;
    } t_cmd_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_cmd;
    logic [3:0] i_from_node;
    logic [3:0] i_to_node;
    logic [7:0] i_weight;
    logic [3:0] i_start_node;
    logic [3:0] i_goal_node;
    logic       o_valid;
    logic [3:0] o_path_index;
    logic [3:0] o_path_node;
    logic [2:0] o_step_direction;
    logic       o_unreachable;
    logic       o_last;

    // bench copy of the weight matrix and the beats still owed by the block
    logic [7:0] edge_cost [NODE_COUNT][NODE_COUNT];
    t_path_beat path_beats_due [$];

    int mismatches;
    int cycle_count;
    int writes_sent;
    int queries_sent;
    int beats_seen;
    int unreach_seen;
    int longest_path;

    grid_shortest_path_router_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_from_node      (i_from_node),
        .i_to_node        (i_to_node),
        .i_weight         (i_weight),
        .i_start_node     (i_start_node),
        .i_goal_node      (i_goal_node),
        .o_valid          (o_valid),
        .o_path_index     (o_path_index),
        .o_path_node      (o_path_node),
        .o_step_direction (o_step_direction),
        .o_unreachable    (o_unreachable),
        .o_last           (o_last)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t watchdog expired with %0d beats outstanding", $time,
                     path_beats_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // grid move between two cells, none when they are not neighbors
    function automatic logic [2:0] grid_move(input int a, input int b);
        int col;
        col = a % GRID_W;
        if (col != 0 && b + 1 == a)
            return DIR_WEST;
        if (col != GRID_W - 1 && a + 1 < NODE_COUNT && b == a + 1)
            return DIR_EAST;
        if (a + GRID_W < NODE_COUNT && b == a + GRID_W)
            return DIR_NORTH;
        if (a >= GRID_W && b + GRID_W == a)
            return DIR_SOUTH;
        return DIR_NONE;
    endfunction

    function automatic t_path_beat fail_beat(input logic [3:0] goal);
        t_path_beat b;
        b = '{idx: 4'd0, node: goal, dir: DIR_NONE, unr: 1'b1, last: 1'b1};
        return b;
    endfunction

    // dijkstra over the bench matrix, queues the path beats of one query
    function automatic void predict_route(input int src, input int dst);
        int         node_dist [NODE_COUNT];
        bit         settled   [NODE_COUNT];
        int         prev      [NODE_COUNT];
        int         hops      [NODE_COUNT];
        int         best, m, w, sum, round, count, j, k;
        bit         found, stop;
        t_path_beat b;
        for (int i = 0; i < NODE_COUNT; i++) begin
            node_dist[i] = int'(DIST_INF);
            settled[i]   = 1'b0;
            prev[i]      = 0;
        end
        node_dist[src] = 0;
        stop = 1'b0;
        for (round = 0; round < NODE_COUNT && !settled[dst] && !stop; round++) begin
            best  = int'(DIST_INF);
            m     = 0;
            found = 1'b0;
            // minimum scan, lowest index wins a tie
            for (int i = 0; i < NODE_COUNT; i++) begin
                if (!settled[i] && node_dist[i] < best) begin
                    best  = node_dist[i];
                    m     = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                stop = 1'b1;
            end else begin
                settled[m] = 1'b1;
                // relax the outgoing edges of the settled node
                for (int i = 0; i < NODE_COUNT; i++) begin
                    w   = int'(edge_cost[m][i]);
                    sum = best + w;
                    if (!settled[i] && w != 0 && sum < int'(DIST_INF) &&
                        sum < node_dist[i]) begin
                        node_dist[i] = sum;
                        prev[i]      = m;
                    end
                end
            end
        end
        if (node_dist[dst] >= int'(DIST_INF)) begin
            path_beats_due.push_back(fail_beat(4'(dst)));
            return;
        end
        // walk back from the goal
        count = 1;
        j = dst;
        while (j != src && count < NODE_COUNT) begin
            j = prev[j];
            count++;
        end
        if (count > PATH_MAX || j != src) begin
            path_beats_due.push_back(fail_beat(4'(dst)));
            return;
        end
        j = dst;
        for (k = count; k > 0; k--) begin
            hops[k-1] = j;
            j = prev[j];
        end
        for (k = 0; k < count; k++) begin
            b.idx  = 4'(k);
            b.node = 4'(hops[k]);
            b.dir  = (k + 1 < count) ? grid_move(hops[k], hops[k+1]) : DIR_NONE;
            b.unr  = 1'b0;
            b.last = (k + 1 == count);
            path_beats_due.push_back(b);
        end
    endfunction

    // row builders; fields that do not apply carry random bits
    function automatic t_cmd_row write_row(input int f, input int t, input int w);
        t_cmd_row r;
        r.cmd    = CMD_WRITE;
        r.from_n = 4'(f);
        r.to_n   = 4'(t);
        r.weight = 8'(w);
        r.src    = 4'($urandom_range(0, 15));
        r.dst    = 4'($urandom_range(0, 15));
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_cmd_row query_row(input int s, input int g);
        t_cmd_row r;
        r.cmd    = CMD_QUERY;
        r.from_n = 4'($urandom_range(0, 15));
        r.to_n   = 4'($urandom_range(0, 15));
        r.weight = 8'($urandom_range(0, 255));
        r.src    = 4'(s);
        r.dst    = 4'(g);
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    // query whose single beat is known up front
    function automatic t_cmd_row typed_row(input int s, input int g, input int node,
                                           input bit unr);
        t_cmd_row r;
        r       = query_row(s, g);
        r.typed = 1'b1;
        r.want  = '{idx: 4'd0, node: 4'(node), dir: DIR_NONE, unr: unr, last: 1'b1};
        return r;
    endfunction

    // random beat: mostly grid-neighbor writes and queries, some stray edges
    function automatic t_cmd_row random_row();
        int pick, a, b, wsel, w;
        pick = $urandom_range(0, 99);
        a    = $urandom_range(0, NODE_COUNT - 1);
        wsel = $urandom_range(0, 19);
        if (wsel < 13)
            w = $urandom_range(1, 6);
        else if (wsel < 16)
            w = 0;
        else
            w = $urandom_range(0, 255);
        if (pick < 55) begin
            case ($urandom_range(0, 3))
                0: b = (a < NODE_COUNT - GRID_W) ? a + GRID_W : a - GRID_W;
                1: b = (a % GRID_W != GRID_W - 1) ? a + 1 : a - 1;
                2: b = (a >= GRID_W) ? a - GRID_W : a + GRID_W;
                default: b = (a % GRID_W != 0) ? a - 1 : a + 1;
            endcase
            return write_row(a, b, w);
        end
        if (pick < 65)
            return write_row(a, $urandom_range(0, NODE_COUNT - 1), w);
        return query_row(a, $urandom_range(0, NODE_COUNT - 1));
    endfunction

    // present one beat, hold it until taken, then book its results
    task automatic send_beat(input t_cmd_row r);
        @(negedge i_clk);
        start        <= 1'b1;
        i_cmd        <= r.cmd;
        i_from_node  <= r.from_n;
        i_to_node    <= r.to_n;
        i_weight     <= r.weight;
        i_start_node <= r.src;
        i_goal_node  <= r.dst;
        do @(posedge i_clk); while (busy);
        if (r.cmd == CMD_WRITE) begin
            edge_cost[r.from_n][r.to_n] = r.weight;
            writes_sent++;
        end else begin
            queries_sent++;
            if (r.typed)
                path_beats_due.push_back(r.want);
            else
                predict_route(int'(r.src), int'(r.dst));
        end
    endtask

    task automatic drain_results();
        while (path_beats_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t mismatch on %s: expected %0d, actual %0d", $time, what,
                         want, got);
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_path_beat want;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (path_beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $display("%0t unexpected beat: expected none, actual node %0d idx %0d",
                             $time, o_path_node, o_path_index);
            end else begin
                want = path_beats_due.pop_front();
                check_field("path_index", want.idx, o_path_index);
                check_field("path_node", want.node, o_path_node);
                check_field("step_direction", want.dir, o_step_direction);
                check_field("unreachable", want.unr, o_unreachable);
                check_field("last", want.last, o_last);
                if (o_unreachable)
                    unreach_seen++;
                if (o_last && !o_unreachable && int'(o_path_index) + 1 > longest_path)
                    longest_path = int'(o_path_index) + 1;
            end
        end
    end

    // stimulus
    initial begin
        t_cmd_row directed_rows [$];
        int       sent, burst, gap;

        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_cmd        = CMD_WRITE;
        i_from_node  = '0;
        i_to_node    = '0;
        i_weight     = '0;
        i_start_node = '0;
        i_goal_node  = '0;
        mismatches   = 0;
        cycle_count  = 0;
        writes_sent  = 0;
        queries_sent = 0;
        beats_seen   = 0;
        unreach_seen = 0;
        longest_path = 0;
        for (int f = 0; f < NODE_COUNT; f++)
            for (int t = 0; t < NODE_COUNT; t++)
                edge_cost[f][t] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: empty graph, small loop, stray edge, north chain
        directed_rows = '{
            typed_row(0, 0, 0, 1'b0),
            typed_row(0, 15, 15, 1'b1),
            typed_row(15, 15, 15, 1'b0),
            write_row(0, 1, 255),
            write_row(1, 5, 1),
            write_row(5, 4, 1),
            write_row(4, 0, 1),
            query_row(0, 4),
            query_row(4, 0),
            query_row(5, 1),
            write_row(0, 15, 1),
            query_row(0, 15),
            write_row(0, 15, 0),
            typed_row(0, 15, 15, 1'b1),
            write_row(3, 7, 2),
            write_row(7, 11, 2),
            write_row(11, 15, 2),
            query_row(3, 15),
            write_row(15, 14, 1),
            query_row(3, 14),
            typed_row(14, 3, 3, 1'b1)
        };
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);
        @(negedge i_clk);
        start <= 1'b0;
        drain_results();

        // longest path: drop shortcuts, then a full serpentine at top weight
        send_beat(write_row(1, 5, 0));
        send_beat(write_row(7, 11, 0));
        send_beat(write_row(11, 15, 0));
        for (int i = 0; i + 1 < NODE_COUNT; i++)
            send_beat(write_row(int'(SNAKE[i]), int'(SNAKE[i+1]), 255));
        send_beat(query_row(0, 12));
        send_beat(query_row(12, 0));
        send_beat(query_row(2, 13));

        // random bursts with random gaps
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst = $urandom_range(1, 10);
            for (int i = 0; i < burst && sent < RANDOM_BEATS; i++) begin
                send_beat(random_row());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            if ($urandom_range(0, 7) == 0) begin
                if (gap == 0) begin
                    @(negedge i_clk);
                    start <= 1'b0;
                end
                drain_results();
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        // let the last query finish, then a short settle window
        drain_results();
        repeat (50) @(posedge i_clk);

        $display("covered %0d weight writes and %0d queries, %0d path beats checked",
                 writes_sent, queries_sent, beats_seen);
        $display("%0d unreachable answers, longest path %0d nodes, %0d mismatches",
                 unreach_seen, longest_path, mismatches);
        if (mismatches == 0 && path_beats_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/gspr_pkg.sv
hw/rtl/gspr_ram.sv
hw/rtl/gspr_ctrl.sv
hw/rtl/gspr_dpath.sv
hw/rtl/grid_shortest_path_router_top.sv
sim/tb_grid_shortest_path_router_top.sv
